// ===== hw/rtl/g2g_pkg.sv =====
// ----------------------------------------------------------------------------
// g2g_pkg
// Shared widths, register indexes and constants of the go-to-goal controller.
// ----------------------------------------------------------------------------
`default_nettype none

package g2g_pkg;

   localparam int POS_W     = 22;
   localparam int HEAD_W    = 16;
   localparam int SPEED_W   = 31;
   localparam int TURN_W    = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 17;

   localparam int CORDIC_STEPS = 16;
   localparam int SQRT_STEPS   = 23;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POSITION_GAIN     = 3'd0,
      CSR_HEADING_GAIN      = 3'd1,
      CSR_HEADING_DEADBAND  = 3'd2,
      CSR_ARRIVAL_TOLERANCE = 3'd3
   } csr_index_type;

   localparam logic [15:0] POSITION_GAIN_RST     = 16'd1280;
   localparam logic [15:0] HEADING_GAIN_RST      = 16'd1280;
   localparam logic [14:0] HEADING_DEADBAND_RST  = 15'd4;
   localparam logic [16:0] ARRIVAL_TOLERANCE_RST = 17'd7;

   localparam logic signed [17:0] PI_Q13      = 18'sd25736;
   localparam logic signed [17:0] TWO_PI_Q13  = 18'sd51472;
   localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;

   localparam logic [16:0] ATAN_TABLE [CORDIC_STEPS] = '{
      17'd51472, 17'd30386, 17'd16055, 17'd8150, 17'd4091, 17'd2047, 17'd1024,
      17'd512, 17'd256, 17'd128, 17'd64, 17'd32, 17'd16, 17'd8, 17'd4, 17'd2
   };

endpackage

`default_nettype wire

// ===== hw/rtl/g2g_if.sv =====
// ----------------------------------------------------------------------------
// g2g interfaces
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface g2g_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [g2g_pkg::POS_W-1:0]      goal_x;
   logic signed [g2g_pkg::POS_W-1:0]      goal_y;
   logic signed [g2g_pkg::POS_W-1:0]      pose_x;
   logic signed [g2g_pkg::POS_W-1:0]      pose_y;
   logic signed [g2g_pkg::HEAD_W-1:0]     pose_heading;
   modport source (output valid, goal_x, goal_y, pose_x, pose_y, pose_heading,
                   input ready);
   modport sink   (input valid, goal_x, goal_y, pose_x, pose_y, pose_heading,
                   output ready);
endinterface

interface g2g_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [g2g_pkg::SPEED_W-1:0]           forward_speed;
   logic signed [g2g_pkg::TURN_W-1:0]     turn_rate;
   logic                                  arrived;
   modport source (output valid, forward_speed, turn_rate, arrived, input ready);
   modport sink   (input valid, forward_speed, turn_rate, arrived, output ready);
endinterface

interface g2g_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [g2g_pkg::CSR_IDX_W-1:0]         index;
   logic [g2g_pkg::CSR_DAT_W-1:0]         data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/go_to_goal_heading_controller.sv =====
// ----------------------------------------------------------------------------
// go_to_goal_heading_controller
// Proportional go-to-goal control: distance and bearing per tick, then a
// rotate-in-place or drive-forward command, plus a stop word on arrival.
// ----------------------------------------------------------------------------
// channel   dir   word
// req_      in    goal_x, goal_y, pose_x, pose_y, pose_heading
// rsp_      out   forward_speed, turn_rate, arrived
// csr_      in    index, data (always ready)
//
// A 28-stage pipeline: a 16-step CORDIC for the bearing and a 23-step
// square root for the distance, one step per stage. One request word enters
// per cycle, but a stalled response freezes every stage; a tick that arrives
// emits two response words and holds the pipeline until its second word
// leaves. Reset clears the valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module go_to_goal_heading_controller (
   input  wire logic clock,
   input  wire logic reset,
   g2g_req_if.sink   req,
   g2g_rsp_if.source rsp,
   g2g_csr_if.sink   csr
);
   import g2g_pkg::*;

   localparam int NUM_STAGES = 28;
   localparam int ST_ERR     = 18;
   localparam int ST_GAIN    = 19;
   localparam int ST_SPEED   = 26;
   localparam int ST_OUT     = 27;

   typedef struct packed {
      logic signed [22:0] dx;
      logic signed [22:0] dy;
      logic signed [15:0] th;
      logic [44:0]        sqx;
      logic [44:0]        sqy;
      logic [45:0]        rad;
      logic [46:0]        root;
      logic signed [41:0] cx;
      logic signed [41:0] cy;
      logic signed [19:0] cz;
      logic               zero;
      logic signed [16:0] err;
      logic               rot;
      logic signed [33:0] tprod;
      logic [38:0]        fprod;
      logic               arr;
      logic [30:0]        fwd;
      logic signed [31:0] turn;
   } stage_type;

   stage_type st_ff [NUM_STAGES];
   stage_type st_in [NUM_STAGES];
   logic [NUM_STAGES-1:0] vld_ff;
   logic phase_ff;
   logic adv;

   logic [15:0] pos_gain_ff;
   logic [15:0] head_gain_ff;
   logic [14:0] deadband_ff;
   logic [16:0] tol_ff;

   // register writes
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_gain_ff  <= POSITION_GAIN_RST;
         head_gain_ff <= HEADING_GAIN_RST;
         deadband_ff  <= HEADING_DEADBAND_RST;
         tol_ff       <= ARRIVAL_TOLERANCE_RST;
      end else if (csr.valid) begin
         unique case (csr.index)
            CSR_POSITION_GAIN:     pos_gain_ff  <= csr.data[15:0];
            CSR_HEADING_GAIN:      head_gain_ff <= csr.data[15:0];
            CSR_HEADING_DEADBAND:  deadband_ff  <= csr.data[14:0];
            CSR_ARRIVAL_TOLERANCE: tol_ff       <= csr.data;
            default: ;
         endcase
      end
   end

   // advance when the output stage is empty or its last word leaves
   assign adv = !vld_ff[ST_OUT] || (rsp.ready && (!st_ff[ST_OUT].arr || phase_ff));
   assign req.ready = adv;

   always_comb begin
      logic signed [41:0] xs;
      logic signed [41:0] ys;
      logic signed [41:0] x0;
      logic signed [41:0] y0;
      logic signed [19:0] at;
      logic [46:0]        bit4;
      logic [46:0]        trial;
      logic signed [19:0] zr;
      logic signed [17:0] e;
      logic signed [17:0] mag;
      logic [39:0]        fsum;
      logic signed [33:0] tsum;
      logic signed [28:0] tq;

      st_in[0]    = st_ff[0];
      st_in[0].dx = 23'(req.goal_x) - 23'(req.pose_x);
      st_in[0].dy = 23'(req.goal_y) - 23'(req.pose_y);
      st_in[0].th = req.pose_heading;

      for (int k = 1; k < NUM_STAGES; k++) begin
         st_in[k] = st_ff[k-1];

         if (k == 1) begin
            st_in[k].sqx  = 45'(st_ff[0].dx * st_ff[0].dx);
            st_in[k].sqy  = 45'(st_ff[0].dy * st_ff[0].dy);
            st_in[k].zero = (st_ff[0].dx == '0) && (st_ff[0].dy == '0);
            x0 = {{3{st_ff[0].dx[22]}}, st_ff[0].dx, 16'd0};
            y0 = {{3{st_ff[0].dy[22]}}, st_ff[0].dy, 16'd0};
            if (st_ff[0].dx[22]) begin
               if (!st_ff[0].dy[22]) begin
                  st_in[k].cx = y0;
                  st_in[k].cy = -x0;
                  st_in[k].cz = HALF_PI_Q16;
               end else begin
                  st_in[k].cx = -y0;
                  st_in[k].cy = x0;
                  st_in[k].cz = -HALF_PI_Q16;
               end
            end else begin
               st_in[k].cx = x0;
               st_in[k].cy = y0;
               st_in[k].cz = '0;
            end
         end

         if (k >= 2 && k < 2 + CORDIC_STEPS) begin
            xs = st_ff[k-1].cx >>> (k - 2);
            ys = st_ff[k-1].cy >>> (k - 2);
            at = signed'({3'd0, ATAN_TABLE[k-2]});
            if (!st_ff[k-1].cy[41]) begin
               st_in[k].cx = st_ff[k-1].cx + ys;
               st_in[k].cy = st_ff[k-1].cy - xs;
               st_in[k].cz = st_ff[k-1].cz + at;
            end else begin
               st_in[k].cx = st_ff[k-1].cx - ys;
               st_in[k].cy = st_ff[k-1].cy + xs;
               st_in[k].cz = st_ff[k-1].cz - at;
            end
         end

         if (k == 2) begin
            st_in[k].rad  = {1'b0, st_ff[1].sqx} + {1'b0, st_ff[1].sqy};
            st_in[k].root = '0;
         end

         if (k >= 3 && k < 3 + SQRT_STEPS) begin
            bit4  = 47'(1) << (2 * (SQRT_STEPS - 1 - (k - 3)));
            trial = st_ff[k-1].root + bit4;
            if ({1'b0, st_ff[k-1].rad} >= trial) begin
               st_in[k].rad  = st_ff[k-1].rad - trial[45:0];
               st_in[k].root = (st_ff[k-1].root >> 1) + bit4;
            end else begin
               st_in[k].root = st_ff[k-1].root >> 1;
            end
         end

         if (k == ST_ERR) begin
            zr = st_ff[k-1].cz + 20'sd4;
            if (st_ff[k-1].zero) begin
               e = -18'(st_ff[k-1].th);
            end else begin
               e = 18'(signed'(zr[19:3])) - 18'(st_ff[k-1].th);
            end
            if (e > PI_Q13) begin
               e = e - TWO_PI_Q13;
            end else if (e < -PI_Q13) begin
               e = e + TWO_PI_Q13;
            end
            st_in[k].err = e[16:0];
         end

         if (k == ST_GAIN) begin
            mag = st_ff[k-1].err[16] ? -18'(st_ff[k-1].err) : 18'(st_ff[k-1].err);
            st_in[k].rot   = mag > signed'({3'd0, deadband_ff});
            st_in[k].tprod = signed'({1'b0, head_gain_ff}) * st_ff[k-1].err;
         end

         if (k == ST_SPEED) begin
            st_in[k].fprod = 39'(pos_gain_ff) * 39'(st_ff[k-1].root[22:0]);
            st_in[k].arr   = st_ff[k-1].root[22:0] <= {6'd0, tol_ff};
         end

         if (k == ST_OUT) begin
            fsum = {1'b0, st_ff[k-1].fprod} + 40'd128;
            tsum = st_ff[k-1].tprod + 34'sd16;
            tq   = tsum[33:5];
            st_in[k].fwd  = '0;
            st_in[k].turn = '0;
            if (st_ff[k-1].rot) begin
               st_in[k].turn = 32'(tq);
            end else if (fsum[39]) begin
               st_in[k].fwd = '1;
            end else begin
               st_in[k].fwd = fsum[38:8];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NUM_STAGES-2:0], req.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   // second word of an arrived tick
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
      end else if (rsp.valid && rsp.ready) begin
         phase_ff <= st_ff[ST_OUT].arr && !phase_ff;
      end
   end

   assign rsp.valid         = vld_ff[ST_OUT];
   assign rsp.forward_speed = phase_ff ? '0 : st_ff[ST_OUT].fwd;
   assign rsp.turn_rate     = phase_ff ? '0 : st_ff[ST_OUT].turn;
   assign rsp.arrived       = phase_ff;

endmodule

`default_nettype wire

// ===== tb/g2g_tb_if_note.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// go_to_goal_heading_controller test package
// Word types shared by the stimulus top and the checker.
// ----------------------------------------------------------------------------
package g2g_test_pkg;
   import g2g_pkg::*;

   typedef struct packed {
      logic signed [POS_W-1:0]  goal_x;
      logic signed [POS_W-1:0]  goal_y;
      logic signed [POS_W-1:0]  pose_x;
      logic signed [POS_W-1:0]  pose_y;
      logic signed [HEAD_W-1:0] pose_heading;
   } tick_word_t;

   typedef struct packed {
      logic [SPEED_W-1:0]       forward_speed;
      logic signed [TURN_W-1:0] turn_rate;
      logic                     arrived;
   } command_word_t;
endpackage

// ===== tb/g2g_command_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// g2g_command_checker
// Watches the request, response and register channels, predicts the motion
// commands of each tick and compares every response word in order.
// ----------------------------------------------------------------------------
module g2g_command_checker
   import g2g_pkg::*;
   import g2g_test_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   g2g_req_if          req,
   g2g_rsp_if          rsp,
   g2g_csr_if          csr,
   output int          fail_count,
   output int          pending_commands
);
   logic [15:0] position_gain;
   logic [15:0] heading_gain;
   logic [14:0] heading_deadband;
   logic [16:0] arrival_tolerance;
   command_word_t expected_commands[$];

   localparam longint ATAN_Q16 [16] = '{51472, 30386, 16055, 8150, 4091, 2047,
      1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

   function automatic longint isqrt_floor(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return longint'(r);
   endfunction

   function automatic longint bearing(longint dx, longint dy);
      longint x, y, z, t, xs, ys;
      x = dx * 65536;
      y = dy * 65536;
      z = 0;
      if (dx == 0 && dy == 0) return 0;
      if (dx < 0) begin
         t = x;
         if (dy >= 0) begin
            x = y; y = -t; z = 102944;
         end else begin
            x = -y; y = t; z = -102944;
         end
      end
      for (int i = 0; i < 16; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x += ys; y -= xs; z += ATAN_Q16[i];
         end else begin
            x -= ys; y += xs; z -= ATAN_Q16[i];
         end
      end
      return (z + 4) >>> 3;
   endfunction

   task automatic predict_commands(tick_word_t w);
      longint dx, dy, distance, e, mag, turn, fwd;
      command_word_t c;
      dx = longint'(w.goal_x) - longint'(w.pose_x);
      dy = longint'(w.goal_y) - longint'(w.pose_y);
      distance = isqrt_floor(dx * dx + dy * dy);
      e = bearing(dx, dy) - longint'(w.pose_heading);
      if (e > 25736) e -= 51472;
      else if (e < -25736) e += 51472;
      mag = e < 0 ? -e : e;
      turn = 0;
      fwd = 0;
      if (mag > longint'(heading_deadband)) begin
         turn = (longint'(heading_gain) * e + 16) >>> 5;
         if (turn > 64'sd2147483647) turn = 64'sd2147483647;
         if (turn < -64'sd2147483648) turn = -64'sd2147483648;
      end else begin
         fwd = (longint'(position_gain) * distance + 128) >>> 8;
         if (fwd > 64'sd2147483647) fwd = 64'sd2147483647;
      end
      c.forward_speed = fwd[30:0];
      c.turn_rate = turn[31:0];
      c.arrived = 1'b0;
      expected_commands.push_back(c);
      if (distance <= longint'(arrival_tolerance)) begin
         c = '0;
         c.arrived = 1'b1;
         expected_commands.push_back(c);
      end
   endtask

   task automatic report_mismatch(string what);
      $display("%0t: response %s", $realtime, what);
      fail_count++;
   endtask

   always @(posedge clock) begin
      command_word_t got, want;
      tick_word_t t;
      if (reset) begin
         position_gain <= POSITION_GAIN_RST;
         heading_gain <= HEADING_GAIN_RST;
         heading_deadband <= HEADING_DEADBAND_RST;
         arrival_tolerance <= ARRIVAL_TOLERANCE_RST;
         expected_commands.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.forward_speed, rsp.turn_rate, rsp.arrived};
            if (expected_commands.size() == 0) begin
               report_mismatch("word with nothing expected");
            end else begin
               want = expected_commands.pop_front();
               if (got.forward_speed !== want.forward_speed)
                  report_mismatch($sformatf("forward_speed %0d, want %0d",
                     got.forward_speed, want.forward_speed));
               if (got.turn_rate !== want.turn_rate)
                  report_mismatch($sformatf("turn_rate %0d, want %0d",
                     got.turn_rate, want.turn_rate));
               if (got.arrived !== want.arrived)
                  report_mismatch($sformatf("arrived %0b, want %0b",
                     got.arrived, want.arrived));
            end
         end
         if (req.valid && req.ready) begin
            t = '{req.goal_x, req.goal_y, req.pose_x, req.pose_y, req.pose_heading};
            predict_commands(t);
         end
         if (csr.valid && csr.ready) begin
            case (csr_index_type'(csr.index))
               CSR_POSITION_GAIN:     position_gain <= csr.data[15:0];
               CSR_HEADING_GAIN:      heading_gain <= csr.data[15:0];
               CSR_HEADING_DEADBAND:  heading_deadband <= csr.data[14:0];
               CSR_ARRIVAL_TOLERANCE: arrival_tolerance <= csr.data;
               default: ;
            endcase
         end
      end
      pending_commands = expected_commands.size();
   end

   initial begin
      fail_count = 0;
      pending_commands = 0;
   end
endmodule

// ===== tb/go_to_goal_heading_controller_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// go_to_goal_heading_controller_test
// Drives directed and random control ticks under several register settings
// with random idling on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module go_to_goal_heading_controller_test;
   import g2g_pkg::*;
   import g2g_test_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 60;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_commands;
   int   idle_cycles;
   bit   quiet_stretch;

   g2g_req_if req ();
   g2g_rsp_if rsp ();
   g2g_csr_if csr ();

   go_to_goal_heading_controller dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr)
   );

   g2g_command_checker checker_i (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr),
      .fail_count(fail_count), .pending_commands(pending_commands)
   );

   always #1 clock = ~clock;

   initial begin
      req.valid = 1'b0;
      req.goal_x = '0;
      req.goal_y = '0;
      req.pose_x = '0;
      req.pose_y = '0;
      req.pose_heading = '0;
      csr.valid = 1'b0;
      csr.index = '0;
      csr.data = '0;
   end

   always @(posedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else rsp.ready <= quiet_stretch || ($urandom_range(99) >= 15);
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
          (csr.valid && csr.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("go_to_goal_heading_controller: mismatch");
         $finish;
      end
   end

   task automatic write_register(csr_index_type idx, logic [CSR_DAT_W-1:0] value);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data <= value;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
   endtask

   task automatic send_tick(tick_word_t w);
      while (!quiet_stretch && $urandom_range(99) < 15) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.goal_x <= w.goal_x;
      req.goal_y <= w.goal_y;
      req.pose_x <= w.pose_x;
      req.pose_y <= w.pose_y;
      req.pose_heading <= w.pose_heading;
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic wait_drained();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_commands != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic tick_word_t make_tick(int gx, int gy, int px, int py, int th);
      tick_word_t w;
      w.goal_x = POS_W'(gx);
      w.goal_y = POS_W'(gy);
      w.pose_x = POS_W'(px);
      w.pose_y = POS_W'(py);
      w.pose_heading = HEAD_W'(th);
      return w;
   endfunction

   function automatic logic signed [POS_W-1:0] rand_pos(int span);
      int v;
      case ($urandom_range(9))
         0: v = 1048576;
         1: v = -1048576;
         2: v = int'($urandom_range(2097151)) - 1048576;
         default: v = int'($urandom_range(2 * span)) - span;
      endcase
      return POS_W'(v);
   endfunction

   function automatic tick_word_t random_tick();
      tick_word_t w;
      int span;
      span = $urandom_range(3) == 0 ? 1048576 : (1 << $urandom_range(20));
      w.pose_x = rand_pos(1048576);
      w.pose_y = rand_pos(1048576);
      case ($urandom_range(5))
         0: begin
            w.goal_x = w.pose_x + POS_W'(int'($urandom_range(16)) - 8);
            w.goal_y = w.pose_y + POS_W'(int'($urandom_range(16)) - 8);
         end
         1: w = 104'({$urandom, $urandom, $urandom, $urandom});
         default: begin
            w.goal_x = w.pose_x + rand_pos(span);
            w.goal_y = w.pose_y + rand_pos(span);
         end
      endcase
      if ($urandom_range(9) == 0) w.pose_heading = HEAD_W'($urandom);
      else w.pose_heading = HEAD_W'(int'($urandom_range(51472)) - 25736);
      return w;
   endfunction

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++) begin
         quiet_stretch = (i >= count / 3 && i < count / 2);
         send_tick(random_tick());
      end
      quiet_stretch = 1'b0;
   endtask

   initial begin
      tick_word_t d [$];
      tick_word_t w;
      quiet_stretch = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      d.push_back(make_tick(0, 0, 0, 0, 0));
      d.push_back(make_tick(1048576, 0, 0, 0, 0));
      d.push_back(make_tick(-1048576, 0, 0, 0, 0));
      d.push_back(make_tick(0, 1048576, 0, 0, 25736));
      d.push_back(make_tick(0, -1048576, 0, 0, -25736));
      d.push_back(make_tick(1048576, 1048576, -1048576, -1048576, 0));
      d.push_back(make_tick(-1048576, -1048576, 1048576, 1048576, 25736));
      d.push_back(make_tick(-1048576, 5, 0, 0, -25736));
      d.push_back(make_tick(-1048576, -5, 0, 0, 25736));
      d.push_back(make_tick(3, 4, 0, 0, 0));
      d.push_back(make_tick(7, 0, 0, 0, 0));
      d.push_back(make_tick(8, 0, 0, 0, 0));
      d.push_back(make_tick(-2097152, 2097151, 2097151, -2097152, -32768));
      d.push_back(make_tick(100000, 0, 0, 0, 32767));
      d.push_back(make_tick(-100000, 0, 0, 0, 20000));
      d.push_back(make_tick(0, 0, 0, 0, 25736));
      foreach (d[i]) send_tick(d[i]);
      wait_drained();

      write_register(CSR_POSITION_GAIN, 17'h0FFFF);
      write_register(CSR_HEADING_GAIN, 17'h0FFFF);
      write_register(CSR_HEADING_DEADBAND, 17'd25736);
      write_register(CSR_ARRIVAL_TOLERANCE, 17'd65536);
      foreach (d[i]) send_tick(d[i]);
      random_phase(400);
      wait_drained();

      write_register(CSR_POSITION_GAIN, 17'd0);
      write_register(CSR_HEADING_GAIN, 17'd0);
      write_register(CSR_HEADING_DEADBAND, 17'd0);
      write_register(CSR_ARRIVAL_TOLERANCE, 17'd0);
      random_phase(300);
      wait_drained();

      write_register(CSR_POSITION_GAIN, 17'h1FFFF);
      write_register(CSR_HEADING_DEADBAND, 17'h1FFFF);
      write_register(CSR_ARRIVAL_TOLERANCE, 17'h1FFFF);
      csr.valid <= 1'b1;
      csr.index <= 3'd7;
      csr.data <= 17'd5;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
      random_phase(300);
      wait_drained();

      for (int k = 0; k < 3; k++) begin
         write_register(CSR_POSITION_GAIN, CSR_DAT_W'($urandom));
         write_register(CSR_HEADING_GAIN, CSR_DAT_W'($urandom));
         write_register(CSR_HEADING_DEADBAND, CSR_DAT_W'($urandom_range(25736)));
         write_register(CSR_ARRIVAL_TOLERANCE, CSR_DAT_W'($urandom_range(65536)));
         random_phase(300);
         wait_drained();
      end

      if (fail_count == 0 && pending_commands == 0)
         $display("go_to_goal_heading_controller: match");
      else
         $display("go_to_goal_heading_controller: mismatch");
      $finish;
   end
endmodule

// ===== files.f =====
hw/rtl/g2g_pkg.sv
hw/rtl/g2g_if.sv
hw/rtl/go_to_goal_heading_controller.sv
tb/g2g_tb_if_note.sv
tb/g2g_command_checker.sv
tb/go_to_goal_heading_controller_test.sv
